/* hw/rtl/celi_pkg.sv */
// Shared constants and types for the complete elliptic integral pair.
package celi_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF = 31;
    localparam logic [63:0] PI_HALF_Q60 = 64'h1921FB54442D1847;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_SQ_PREP,
        ST_SQRT,
        ST_DIV,
        ST_SQUARE,
        ST_ACC,
        ST_SAT,
        ST_NEXT,
        ST_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_RUN_K,
        T_START_KP,
        T_RUN_KP,
        T_SEND
    } top_state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } unit_op_t;

endpackage

/* hw/rtl/complete_elliptic_integral_pair.sv */
// Top level: complete elliptic integrals K and K' by Landen descent.
//
//  channel | dir | tdata fields (low bit up)                | tuser fields
//  s_      | in  | modulus_k[31:0]                          | -
//  m_      | out | integral_k[31:0], integral_kp[31:0]      | k_infinite, kp_infinite
//
// One word takes up to two descents of up to MAX_STEPS Landen steps; each step
// runs five operations (multiply, square root, divide, multiply, multiply)
// through one shared bit-serial unit. The unit is the limit. s_axis_tready is
// low while a word is in work or a result waits on m_axis_tready. Reset clears
// control only.
module complete_elliptic_integral_pair
    import celi_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // modulus_k
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // integral_k, integral_kp
    output logic [1:0]  m_axis_tuser    // k_infinite, kp_infinite
);

    localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;

    top_state_t   state_reg, state_next;
    logic [63:0]  k_reg, k_next;
    logic [31:0]  ik_reg, ik_next, ikp_reg, ikp_next;
    logic [1:0]   flag_reg, flag_next;
    logic         go;
    logic [63:0]  k_start;
    logic         finished;
    logic [63:0]  product, kc_first;
    logic         u_start, u_done;
    unit_op_t     u_op;
    logic [127:0] u_a, u_res;
    logic [63:0]  u_b;
    logic [63:0]  k_conv;

    // move the Q1.31 input to Q.F
    always_comb begin
        if (FRAC_BITS >= 31) k_conv = {32'd0, s_axis_tdata} << (FRAC_BITS - 31);
        else                 k_conv = {32'd0, s_axis_tdata} >> (31 - FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= T_IDLE;
        else          state_reg <= state_next;
        k_reg    <= k_next;
        ik_reg   <= ik_next;
        ikp_reg  <= ikp_next;
        flag_reg <= flag_next;
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        ik_next    = ik_reg;
        ikp_next   = ikp_reg;
        flag_next  = flag_reg;
        go         = 1'b0;
        k_start    = k_reg;
        case (state_reg)
            T_IDLE: if (s_axis_tvalid) begin
                if (s_axis_tdata[31]) begin
                    ik_next    = '1;
                    ikp_next   = PI_HALF_Q60[63:32];
                    flag_next  = 2'b01;
                    state_next = T_SEND;
                end else if (s_axis_tdata == 32'd0) begin
                    ik_next    = PI_HALF_Q60[63:32];
                    ikp_next   = '1;
                    flag_next  = 2'b10;
                    state_next = T_SEND;
                end else begin
                    k_next     = k_conv;
                    k_start    = k_conv;
                    go         = 1'b1;
                    flag_next  = 2'b00;
                    state_next = T_RUN_K;
                end
            end
            T_RUN_K: if (finished) begin
                ik_next = product[63:32];
                // a zero modulus never entered a step: complement is one
                k_next  = (k_reg == 64'd0) ? ONE_F : kc_first;
                state_next = T_START_KP;
            end
            T_START_KP: begin
                if (k_reg >= ONE_F || k_reg == 64'd0) begin
                    ikp_next   = '1;
                    flag_next  = 2'b10;
                    state_next = T_SEND;
                end else begin
                    go         = 1'b1;
                    state_next = T_RUN_KP;
                end
            end
            T_RUN_KP: if (finished) begin
                ikp_next   = product[63:32];
                state_next = T_SEND;
            end
            T_SEND: if (m_axis_tready) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == T_IDLE);
    assign m_axis_tvalid = (state_reg == T_SEND);
    assign m_axis_tdata  = {ikp_reg, ik_reg};
    assign m_axis_tuser  = flag_reg;

    celi_seq #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_seq (
        .aclk, .aresetn, .go, .k_start, .finished, .product, .kc_first,
        .u_start, .u_op, .u_a, .u_b, .u_done, .u_res
    );

    celi_unit u_unit (
        .aclk, .aresetn, .start(u_start), .op(u_op), .arg_a(u_a), .arg_b(u_b),
        .done(u_done), .result(u_res)
    );

endmodule

/* hw/rtl/celi_unit.sv */
// Shared iterative unit: shift-add multiply, bit-serial square root, restoring divide.
module celi_unit
    import celi_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  unit_op_t     op,
    input  logic [127:0] arg_a,
    input  logic [63:0]  arg_b,
    output logic         done,
    output logic [127:0] result
);

    logic [127:0] acc_reg, acc_next;
    logic [127:0] a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] rem_reg, rem_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    unit_op_t     op_reg, op_next;

    logic [129:0] sq_trial;
    logic [128:0] div_rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        op_reg  <= op_next;
    end

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        sq_trial  = '0;
        div_rem   = '0;
        if (start) begin
            busy_next = 1'b1;
            op_next   = op;
            a_next    = arg_a;
            b_next    = arg_b;
            acc_next  = '0;
            rem_next  = '0;
            cnt_next  = 7'd0;
        end else if (busy_reg) begin
            case (op_reg)
                OP_MUL: begin
                    // one multiplier bit per cycle, LSB first
                    if (b_reg[cnt_reg[5:0]]) begin
                        acc_next = acc_reg + (a_reg << cnt_reg[5:0]);
                    end
                end
                OP_SQRT: begin
                    // two radicand bits per cycle, one root bit
                    sq_trial = {rem_reg, a_reg[127:126]} - {acc_reg[127:0], 2'b01};
                    if (!sq_trial[129]) begin
                        rem_next = sq_trial[127:0];
                        acc_next = {acc_reg[126:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[125:0], a_reg[127:126]};
                        acc_next = {acc_reg[126:0], 1'b0};
                    end
                    a_next = {a_reg[125:0], 2'b00};
                end
                OP_DIV: begin
                    div_rem = {rem_reg, a_reg[127]} - {65'd0, b_reg};
                    if (!div_rem[128]) begin
                        rem_next = div_rem[127:0];
                        acc_next = {acc_reg[126:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[126:0], a_reg[127]};
                        acc_next = {acc_reg[126:0], 1'b0};
                    end
                    a_next = {a_reg[126:0], 1'b0};
                end
                default: ;
            endcase
            cnt_next = cnt_reg + 7'd1;
            if ((op_reg == OP_DIV && cnt_reg == 7'd127) ||
                (op_reg != OP_DIV && cnt_reg == 7'd63)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

/* hw/rtl/celi_seq.sv */
// Landen descent sequencer driving the shared unit.
module celi_seq
    import celi_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         go,
    input  logic [63:0]  k_start,
    output logic         finished,
    output logic [63:0]  product,
    output logic [63:0]  kc_first,
    output logic         u_start,
    output unit_op_t     u_op,
    output logic [127:0] u_a,
    output logic [63:0]  u_b,
    input  logic         u_done,
    input  logic [127:0] u_res
);

    localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;
    localparam int SW = $clog2(MAX_STEPS + 1);

    seq_state_t state_reg, state_next;
    logic [63:0] kn_reg, kn_next;
    logic [63:0] kc_reg, kc_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] kc0_reg, kc0_next;
    logic        first_reg, first_next;
    logic [SW-1:0] step_reg, step_next;
    logic        issued_reg, issued_next;
    logic [127:0] mshift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
        kn_reg    <= kn_next;
        kc_reg    <= kc_next;
        acc_reg   <= acc_next;
        kc0_reg   <= kc0_next;
        first_reg <= first_next;
        step_reg  <= step_next;
    end

    assign mshift = u_res >> FRAC_BITS;

    // next state and data path
    always_comb begin
        state_next  = state_reg;
        kn_next     = kn_reg;
        kc_next     = kc_reg;
        acc_next    = acc_reg;
        kc0_next    = kc0_reg;
        first_next  = first_reg;
        step_next   = step_reg;
        issued_next = issued_reg;
        case (state_reg)
            ST_IDLE: if (go) begin
                kn_next    = k_start;
                acc_next   = PI_HALF_Q60;
                step_next  = '0;
                first_next = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (kn_reg == 64'd0 || step_reg == SW'(MAX_STEPS)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next  = ST_SQ_PREP;
                    issued_next = 1'b0;
                end
            end
            ST_SQ_PREP: begin
                // (1-k)(1+k), held in the unit for the root
                issued_next = 1'b1;
                if (u_done && issued_reg) begin
                    state_next  = ST_SQRT;
                    issued_next = 1'b0;
                end
            end
            ST_SQRT: begin
                issued_next = 1'b1;
                if (u_done && issued_reg) begin
                    if (first_reg) kc0_next = u_res[63:0];
                    first_next  = 1'b0;
                    kc_next     = u_res[63:0];
                    state_next  = ST_DIV;
                    issued_next = 1'b0;
                end
            end
            ST_DIV: begin
                issued_next = 1'b1;
                if (u_done && issued_reg) begin
                    kc_next     = u_res[63:0];
                    state_next  = ST_SQUARE;
                    issued_next = 1'b0;
                end
            end
            ST_SQUARE: begin
                issued_next = 1'b1;
                if (u_done && issued_reg) begin
                    kn_next     = mshift[63:0];
                    state_next  = ST_ACC;
                    issued_next = 1'b0;
                end
            end
            ST_ACC: begin
                issued_next = 1'b1;
                if (u_done && issued_reg) begin
                    acc_next    = (mshift[127:64] != 64'd0) ? '1 : mshift[63:0];
                    step_next   = step_reg + SW'(1);
                    state_next  = ST_CHECK;
                    issued_next = 1'b0;
                end
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // unit command
    always_comb begin
        u_start = 1'b0;
        u_op    = OP_MUL;
        u_a     = '0;
        u_b     = '0;
        case (state_reg)
            ST_SQ_PREP: begin
                u_start = !issued_reg;
                u_a     = {64'd0, ONE_F - kn_reg};
                u_b     = ONE_F + kn_reg;
            end
            ST_SQRT: begin
                // full-width product still sits in the unit result
                u_start = !issued_reg;
                u_op    = OP_SQRT;
                u_a     = u_res;
            end
            ST_DIV: begin
                u_start = !issued_reg;
                u_op    = OP_DIV;
                u_a     = {64'd0, kn_reg} << FRAC_BITS;
                u_b     = ONE_F + kc_reg;
            end
            ST_SQUARE: begin
                u_start = !issued_reg;
                u_a     = {64'd0, kc_reg};
                u_b     = kc_reg;
            end
            ST_ACC: begin
                u_start = !issued_reg;
                u_a     = {64'd0, acc_reg};
                u_b     = ONE_F + kn_reg;
            end
            default: ;
        endcase
    end

    assign finished = (state_reg == ST_OUT);
    assign product  = acc_reg;
    assign kc_first = kc0_reg;

endmodule
